>>> src/iee_pkg.sv
// Shared types and constants for the infix expression evaluator.
// No dependencies.
`default_nettype none
package iee_pkg;
    localparam int DEFAULT_DATA_WIDTH = 32;
    localparam int VALUE_WIDTH        = 32;
    localparam int CHAR_WIDTH         = 8;
    localparam int QUEUE_DEPTH        = 4;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // item kinds passed from front to back
    typedef enum logic [1:0] {
        KIND_DIGIT = 2'd0,
        KIND_OPER  = 2'd1,
        KIND_NONE  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] digit;
        op_t        op;
        logic       last;
    } token_t;

    localparam int TOKEN_WIDTH = $bits(token_t);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
endpackage
`default_nettype wire

>>> src/iee_front.sv
// Front end: accepts characters, classifies them into tokens.
// Depends on iee_pkg.
`default_nettype none
module iee_front import iee_pkg::*; (
    input  wire logic [CHAR_WIDTH-1:0] char_code,
    input  wire logic                  last,
    output token_t                     token
);
    always_comb begin
        token.kind  = KIND_NONE;
        token.digit = 4'd0;
        token.op    = OP_ADD;
        token.last  = last;
        if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
            token.kind  = KIND_DIGIT;
            token.digit = 4'(char_code - CH_ZERO);
        end else begin
            unique case (char_code)
                CH_PLUS:  begin token.kind = KIND_OPER; token.op = OP_ADD; end
                CH_MINUS: begin token.kind = KIND_OPER; token.op = OP_SUB; end
                CH_STAR:  begin token.kind = KIND_OPER; token.op = OP_MUL; end
                CH_SLASH: begin token.kind = KIND_OPER; token.op = OP_DIV; end
                default:  token.kind = KIND_NONE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> src/iee_fifo.sv
// Short token queue between front and back.
// Depends on iee_pkg.
`default_nettype none
module iee_fifo import iee_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   wr_valid,
    output logic        wr_ready,
    input  wire token_t wr_data,
    output logic        rd_valid,
    input  wire logic   rd_ready,
    output token_t      rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    token_t mem_reg [DEPTH];
    logic [AW-1:0] wptr_reg, rptr_reg;
    logic [AW:0]   count_reg;
    logic wr_en, rd_en;

    assign wr_ready = count_reg != (AW+1)'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rptr_reg];
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wptr_reg] <= wr_data;
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (wr_en)
                wptr_reg <= (wptr_reg == AW'(DEPTH-1)) ? '0 : wptr_reg + 1'b1;
            if (rd_en)
                rptr_reg <= (rptr_reg == AW'(DEPTH-1)) ? '0 : rptr_reg + 1'b1;
            count_reg <= count_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end
endmodule
`default_nettype wire

>>> src/iee_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on iee_pkg.
`default_nettype none
module iee_divider import iee_pkg::*; #(
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DATA_WIDTH-1:0] dividend,
    input  wire logic [DATA_WIDTH-1:0] divisor,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      quotient
);
    localparam int CW = $clog2(DATA_WIDTH + 1);
    logic [DATA_WIDTH-1:0] rem_reg, quo_reg, den_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  neg_reg, busy_reg;
    logic [DATA_WIDTH:0]   trial;
    logic [DATA_WIDTH-1:0] a_mag, b_mag;

    assign a_mag = dividend[DATA_WIDTH-1] ? -dividend : dividend;
    assign b_mag = divisor[DATA_WIDTH-1]  ? -divisor  : divisor;
    assign trial = {rem_reg, quo_reg[DATA_WIDTH-1]} - {1'b0, den_reg};
    assign done     = busy_reg && cnt_reg == '0;
    assign quotient = neg_reg ? -quo_reg : quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DATA_WIDTH);
            rem_reg  <= '0;
            quo_reg  <= a_mag;
            den_reg  <= b_mag;
            neg_reg  <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
                if (!trial[DATA_WIDTH]) begin
                    rem_reg <= trial[DATA_WIDTH-1:0];
                    quo_reg <= {quo_reg[DATA_WIDTH-2:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[DATA_WIDTH-2:0], quo_reg[DATA_WIDTH-1]};
                    quo_reg <= {quo_reg[DATA_WIDTH-2:0], 1'b0};
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> src/iee_back.sv
// Back end: stacks, reduction sequencer and result register.
// Depends on iee_pkg and iee_divider.
`default_nettype none
module iee_back import iee_pkg::*; #(
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              tok_valid,
    output logic                   tok_ready,
    input  wire token_t            tok,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output logic [VALUE_WIDTH-1:0] res_value,
    output logic                   res_dbz
);
    localparam int MW = (DATA_WIDTH > VALUE_WIDTH) ? DATA_WIDTH : VALUE_WIDTH;
    typedef enum logic [2:0] {S_IDLE, S_REDUCE, S_DIV, S_FINISH} state_t;
    typedef enum logic [1:0] {M_NONE, M_ADD, M_HIGH} mode_t;

    state_t state_reg;
    mode_t  mode_reg;
    logic [DATA_WIDTH-1:0] accum_reg;
    logic [DATA_WIDTH-1:0] vs_reg [3];
    logic [1:0] vcnt_reg, ocnt_reg;
    op_t        os_reg [2];
    op_t        pend_op_reg;
    logic       pend_push_reg, last_reg, err_reg;

    logic [DATA_WIDTH-1:0] a, b, alu, div_q, acc10, prod;
    op_t  top_op;
    logic can_reduce, want_reduce, div_start, div_done;

    assign a      = vs_reg[2'(vcnt_reg - 2'd2)];
    assign b      = vs_reg[2'(vcnt_reg - 2'd1)];
    assign top_op = os_reg[1'(ocnt_reg - 2'd1)];
    assign prod   = a * b;
    assign acc10  = DATA_WIDTH'(accum_reg * DATA_WIDTH'(10)
                    + DATA_WIDTH'(tok.digit));
    assign can_reduce  = ocnt_reg != 2'd0 && vcnt_reg >= 2'd2;
    assign want_reduce = can_reduce && (mode_reg == M_ADD ||
                         (mode_reg == M_HIGH && (top_op == OP_MUL || top_op == OP_DIV)));
    assign div_start = state_reg == S_REDUCE && want_reduce && top_op == OP_DIV
                       && b != '0;
    // result register parts the sides: a held result blocks tokens only while the next result waits in S_FINISH
    assign tok_ready = state_reg == S_IDLE;

    always_comb begin
        case (top_op)
            OP_ADD:  alu = a + b;
            OP_SUB:  alu = a - b;
            OP_MUL:  alu = prod;
            default: alu = '0;
        endcase
    end

    iee_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(a), .divisor(b), .done(div_done), .quotient(div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            mode_reg      <= M_NONE;
            accum_reg     <= '0;
            vcnt_reg      <= '0;
            ocnt_reg      <= '0;
            err_reg       <= 1'b0;
            pend_push_reg <= 1'b0;
            last_reg      <= 1'b0;
            res_valid     <= 1'b0;
            for (int i = 0; i < 3; i++) vs_reg[i] <= '0;
            for (int i = 0; i < 2; i++) os_reg[i] <= OP_ADD;
        end else begin
            if (res_valid && res_ready) res_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (tok_valid && tok_ready) begin
                    last_reg      <= tok.last;
                    pend_op_reg   <= tok.op;
                    pend_push_reg <= tok.kind == KIND_OPER;
                    if (tok.kind == KIND_DIGIT) begin
                        accum_reg <= acc10;
                        if (tok.last) begin
                            if (vcnt_reg != 2'd3) begin
                                vs_reg[vcnt_reg] <= acc10;
                                vcnt_reg <= vcnt_reg + 1'b1;
                            end
                            accum_reg <= '0;
                            mode_reg  <= M_ADD;
                            state_reg <= S_REDUCE;
                        end
                    end else if (tok.kind == KIND_OPER || tok.last) begin
                        if (vcnt_reg != 2'd3) begin
                            vs_reg[vcnt_reg] <= accum_reg;
                            vcnt_reg <= vcnt_reg + 1'b1;
                        end
                        accum_reg <= '0;
                        mode_reg  <= (tok.kind == KIND_OPER &&
                                      (tok.op == OP_MUL || tok.op == OP_DIV))
                                     ? M_HIGH : M_ADD;
                        state_reg <= S_REDUCE;
                    end
                end
                S_REDUCE: begin
                    if (want_reduce) begin
                        if (top_op == OP_DIV && b != '0) begin
                            state_reg <= S_DIV;
                        end else begin
                            if (top_op == OP_DIV) err_reg <= 1'b1;
                            vs_reg[2'(vcnt_reg - 2'd2)] <= alu;
                            vcnt_reg <= vcnt_reg - 1'b1;
                            ocnt_reg <= ocnt_reg - 1'b1;
                        end
                    end else begin
                        // reductions done; push operator, then maybe finish
                        if (pend_push_reg && ocnt_reg != 2'd2) begin
                            os_reg[ocnt_reg[0]] <= pend_op_reg;
                            ocnt_reg <= ocnt_reg + 1'b1;
                        end
                        pend_push_reg <= 1'b0;
                        if (last_reg && pend_push_reg) begin
                            // operator that was also last: push accum (zero), then reduce all
                            if (vcnt_reg != 2'd3) begin
                                vs_reg[vcnt_reg] <= '0;
                                vcnt_reg <= vcnt_reg + 1'b1;
                            end
                            mode_reg <= M_ADD;
                        end else if (last_reg) begin
                            state_reg <= S_FINISH;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_DIV: if (div_done) begin
                    vs_reg[2'(vcnt_reg - 2'd2)] <= div_q;
                    vcnt_reg  <= vcnt_reg - 1'b1;
                    ocnt_reg  <= ocnt_reg - 1'b1;
                    state_reg <= S_REDUCE;
                end
                // wait here while the previous result is still held
                S_FINISH: if (!res_valid || res_ready) begin
                    res_value <= (vcnt_reg != 2'd0)
                        ? VALUE_WIDTH'($signed(MW'($signed(b))))
                        : '0;
                    res_dbz   <= err_reg;
                    res_valid <= 1'b1;
                    accum_reg <= '0;
                    vcnt_reg  <= '0;
                    ocnt_reg  <= '0;
                    err_reg   <= 1'b0;
                    last_reg  <= 1'b0;
                    mode_reg  <= M_NONE;
                    for (int i = 0; i < 3; i++) vs_reg[i] <= '0;
                    for (int i = 0; i < 2; i++) os_reg[i] <= OP_ADD;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> src/infix_expression_evaluator_core.sv
// Infix expression evaluator: front classifier, token queue, back evaluator.
// Depends on iee_pkg, iee_front, iee_fifo, iee_back.
// Flow: a digit or space that is not last is taken by the back end with no
// reduction; an operator takes up to two reductions, each done by the ALU or,
// when it is a division, by the bit-serial divider, which sets the worst case.
// The last item adds a full reduction and a load of the result register,
// which waits there only while the previous result is still held.
// Reset: synchronous, active low; clears stacks, queue and result valid.
`default_nettype none
module infix_expression_evaluator_core import iee_pkg::*; #(
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // last character of the expression
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // [31:0] value, [32] div_by_zero
);
    token_t ftok, qtok;
    logic   q_valid, q_ready;
    logic [VALUE_WIDTH-1:0] value;
    logic   dbz;

    // classify incoming characters
    iee_front u_front (.char_code(s_tdata), .last(s_tlast), .token(ftok));

    // decouple front and back
    iee_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(s_tvalid), .wr_ready(s_tready), .wr_data(ftok),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(qtok)
    );

    // evaluate with value and operator stacks
    iee_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .tok_valid(q_valid), .tok_ready(q_ready), .tok(qtok),
        .res_valid(m_tvalid), .res_ready(m_tready),
        .res_value(value), .res_dbz(dbz)
    );

    assign m_tdata = {7'd0, dbz, value};
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Testbench for infix_expression_evaluator_core: streams expression characters,
// predicts each emitted value and divide-by-zero flag, and checks results in order.
// Depends on iee_pkg and the RTL under src.
`default_nettype none
module tb_top;
    import iee_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Expected result of one expression.
    typedef struct {
        logic [31:0] value;
        logic        dbz;
    } expr_result_t;

    // Scoreboard: owns the expression predictor and the queue of pending results.
    class expr_scoreboard;
        logic [31:0]  accum;
        logic [31:0]  vals [3];
        int           nvals;
        op_t          ops [2];
        int           nops;
        bit           err;
        expr_result_t pending [$];
        int           errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            accum = '0;
            nvals = 0;
            nops = 0;
            err = 0;
            for (int i = 0; i < 3; i++) vals[i] = '0;
            for (int i = 0; i < 2; i++) ops[i] = OP_ADD;
        endfunction

        function void push_val(logic [31:0] v);
            if (nvals < 3) begin
                vals[nvals] = v;
                nvals++;
            end
        endfunction

        function logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
            logic [31:0] ma, mb, q;
            if (b == 0) begin
                err = 1;
                return '0;
            end
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            if (a[31] != b[31]) q = -q;
            return q;
        endfunction

        function void reduce_top();
            logic [31:0] a, b, r;
            op_t o;
            if (nops == 0 || nvals < 2) return;
            nops--;
            o = ops[nops];
            b = vals[nvals-1];
            a = vals[nvals-2];
            nvals -= 2;
            case (o)
                OP_ADD: r = a + b;
                OP_SUB: r = a - b;
                OP_MUL: r = a * b;
                default: r = quotient(a, b);
            endcase
            push_val(r);
        endfunction

        function void apply_op(op_t o);
            push_val(accum);
            accum = '0;
            if (o == OP_ADD || o == OP_SUB) begin
                while (nops > 0 && nvals >= 2) reduce_top();
            end else begin
                while (nops > 0 && nvals >= 2 && (ops[nops-1] == OP_MUL ||
                       ops[nops-1] == OP_DIV))
                    reduce_top();
            end
            if (nops < 2) begin
                ops[nops] = o;
                nops++;
            end
        endfunction

        // Note one accepted input item.
        function void note_char(logic [7:0] c, logic lst);
            expr_result_t r;
            if (c >= CH_ZERO && c <= CH_NINE) accum = accum * 10 + 32'(c - CH_ZERO);
            else if (c == CH_PLUS) apply_op(OP_ADD);
            else if (c == CH_MINUS) apply_op(OP_SUB);
            else if (c == CH_STAR) apply_op(OP_MUL);
            else if (c == CH_SLASH) apply_op(OP_DIV);
            if (!lst) return;
            push_val(accum);
            accum = '0;
            while (nops > 0 && nvals >= 2) reduce_top();
            r.value = (nvals > 0) ? vals[nvals-1] : '0;
            r.dbz = err;
            pending.push_back(r);
            clear();
        endfunction

        // Check one accepted result against the oldest expectation.
        function void check_result(logic [39:0] d);
            expr_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result value=%0d dbz=%0b", $realtime,
                         $signed(d[31:0]), d[32]);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.value) begin
                $display("%0t: value mismatch expected=%0d actual=%0d", $realtime,
                         $signed(e.value), $signed(d[31:0]));
                errors++;
            end
            if (d[32] !== e.dbz) begin
                $display("%0t: div_by_zero mismatch expected=%0b actual=%0b",
                         $realtime, e.dbz, d[32]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    expr_scoreboard sb;
    bit stim_done;
    bit hold_go;        // starts the long receiver hold-off
    bit hold_rx;        // long receiver hold-off request
    int rx_mode;

    infix_expression_evaluator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b0; #1;
        aclk = 1'b1; #1;
    end

    // Character queue awaiting transmission.
    logic [8:0] char_fifo [$];
    int burst_left;

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 3))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // Queue an expression given as a string; last flag on its final char.
    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            char_fifo.push_back({(i == s.len() - 1) ? 1'b1 : 1'b0, s[i]});
    endtask

    // Random expression, not always well-formed, with random spaces and rare noise.
    task automatic queue_random_expr();
        int nterms, nd;
        logic [7:0] c;
        logic [8:0] q [$];
        nterms = $urandom_range(1, 5);
        for (int t = 0; t < nterms; t++) begin
            if (t > 0) q.push_back({1'b0, pick_op()});
            nd = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0 && t > 0) nd = 1;
            for (int d = 0; d < nd; d++) begin
                c = 8'(CH_ZERO + $urandom_range(0, 9));
                if (t > 0 && nd == 1 && $urandom_range(0, 3) == 0) c = CH_ZERO;
                q.push_back({1'b0, c});
            end
            if ($urandom_range(0, 5) == 0) q.push_back({1'b0, 8'h20});
            if ($urandom_range(0, 15) == 0) q.push_back({1'b0, 8'($urandom())});
        end
        if ($urandom_range(0, 9) == 0) q.push_back({1'b0, pick_op()});
        if ($urandom_range(0, 9) == 0) q.push_back({1'b0, 8'($urandom())});
        // empty expression: a lone space carries the last flag
        if (q.size() == 0) q.push_back({1'b0, 8'h20});
        q[q.size()-1][8] = 1'b1;
        foreach (q[i]) char_fifo.push_back(q[i]);
    endtask

    // Send everything queued, in bursts with random gaps.
    task automatic send_all();
        logic [8:0] it;
        int gap;
        while (char_fifo.size() > 0) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                burst_left = $urandom_range(1, 30);
            end
            it = char_fifo.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= it[7:0];
            s_tlast  <= it[8];
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            sb.note_char(it[7:0], it[8]);
            burst_left--;
            @(negedge aclk);
        end
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_results();
        while (sb.pending.size() > 0) @(negedge aclk);
    endtask

    // Receiver: stall pattern changes mode now and then; long hold on request.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_rx) begin
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 63) == 0) rx_mode = $urandom_range(0, 2);
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Long receiver hold-off, counted here, while the sender keeps going.
    initial begin
        hold_rx = 1'b0;
        wait (hold_go == 1'b1 && stim_done == 1'b0 && aresetn === 1'b1);
        @(negedge aclk);
        hold_rx = 1'b1;
        repeat (600) @(negedge aclk);
        hold_rx = 1'b0;
    end

    initial begin
        sb = new();
        stim_done = 0;
        hold_go = 0;
        rx_mode = 0;
        burst_left = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: precedence, unary minus, trailing operator, divide by zero,
        // most negative over zero, operand wrap, ignored characters.
        queue_text("7");
        queue_text("2+3*4");
        queue_text("8-6/4-1");
        queue_text("-5");
        queue_text("3+");
        queue_text("9/0+1");
        queue_text("-7/2");
        queue_text("0-2147483648/0-1");
        queue_text("4294967295*3");
        queue_text("99999999999");
        queue_text(" 1 x+ 2\xff");
        queue_text("6*7/3*2-10");
        queue_text("");
        char_fifo.push_back({1'b1, 8'h20});
        char_fifo.push_back({1'b1, 8'h00});
        char_fifo.push_back({1'b1, 8'hff});
        queue_text("+-*/");
        send_all();
        // Sender pauses until every result has come.
        wait_results();

        for (int n = 0; n < 70; n++) begin
            if (n == 5) hold_go = 1'b1;
            queue_random_expr();
            send_all();
            if (n == 35) wait_results();
        end
        stim_done = 1;
        wait_results();
        repeat (200) @(negedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #600000;
        $display("tb_top: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
